/* rtl/tgt_pkg.sv */
`default_nettype none
package tgt_pkg;

    // Field widths.
    localparam int POS_W   = 16;
    localparam int SUM_W   = 32;
    localparam int EL_W    = 20;
    localparam int LIM_W   = 16;
    localparam int RET_W   = 16;
    localparam int FLOOR_W = 31;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int PHASE_W = 2;

    // Instant rate divider: |step * 1000| plus half the divisor fits in 26 bits.
    localparam int NUM_W     = 26;
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 65;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_TRAVEL   = 2'd0;
    localparam logic [IDX_W-1:0] REG_DURATION = 2'd1;
    localparam logic [IDX_W-1:0] REG_RETAIN   = 2'd2;
    localparam logic [IDX_W-1:0] REG_FLOOR    = 2'd3;

    // Phase codes.
    localparam logic [PHASE_W-1:0] PH_ABSENT   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PRESSED  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_TRAVEL   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASED = 2'd3;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ABANDON,
        OP_CANCEL,
        OP_DEFER,
        OP_PRESS,
        OP_ABSENT,
        OP_CARRY,
        OP_DIV_STEP,
        OP_MUL_RATE,
        OP_MUL_INST,
        OP_ADD,
        OP_ROUND,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_L,
        OP_REACH,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic pressed;
        logic released;
        logic held;
        logic live;
        logic rel_pend;
        logic canc_pend;
        logic el_zero;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/tgt_intf.sv */
`default_nettype none
interface tgt_in_if import tgt_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic                    contact_pressed;
    logic                    contact_released;
    logic                    contact_held;
    logic signed [POS_W-1:0] sample_x;
    logic signed [POS_W-1:0] sample_y;
    logic signed [POS_W-1:0] step_x;
    logic signed [POS_W-1:0] step_y;
    logic [EL_W-1:0]         elapsed_us;

    modport source (output valid, mode, contact_pressed, contact_released, contact_held,
                    sample_x, sample_y, step_x, step_y, elapsed_us, input ready);
    modport sink (input valid, mode, contact_pressed, contact_released, contact_held,
                  sample_x, sample_y, step_x, step_y, elapsed_us, output ready);
endinterface

interface tgt_out_if import tgt_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [PHASE_W-1:0]      phase;
    logic                    tap_resolved;
    logic                    fling_resolved;
    logic                    travel_exceeded;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic signed [POS_W-1:0] position_x;
    logic signed [POS_W-1:0] position_y;
    logic signed [SUM_W-1:0] total_x;
    logic signed [SUM_W-1:0] total_y;
    logic [SUM_W-1:0]        held_time;
    logic signed [SUM_W-1:0] speed_y;

    modport source (output valid, phase, tap_resolved, fling_resolved, travel_exceeded,
                    origin_x, origin_y, position_x, position_y, total_x, total_y,
                    held_time, speed_y, input ready);
    modport sink (input valid, phase, tap_resolved, fling_resolved, travel_exceeded,
                  origin_x, origin_y, position_x, position_y, total_x, total_y,
                  held_time, speed_y, output ready);
endinterface
`default_nettype wire

/* rtl/tgt_ctrl.sv */
`default_nettype none
module tgt_ctrl import tgt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECIDE = 11'b000_0000_0010,
        S_DIV    = 11'b000_0000_0100,
        S_MUL_A  = 11'b000_0000_1000,
        S_MUL_B  = 11'b000_0001_0000,
        S_ADD    = 11'b000_0010_0000,
        S_ROUND  = 11'b000_0100_0000,
        S_SQ_X   = 11'b000_1000_0000,
        S_SQ_Y   = 11'b001_0000_0000,
        S_SQ_L   = 11'b010_0000_0000,
        S_REACH  = 11'b100_0000_0000
    } t_state;

    // The emit step is folded into the state after the last update: a separate
    // flag tells the idle-bound path that a beat still has to be written out.
    t_state r_state, n_state;
    logic   r_emit, n_emit;

    assign o_in_ready = (r_state == S_IDLE) && !r_emit;

    // Next state and command.
    always_comb begin
        n_state  = r_state;
        n_emit   = r_emit;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (r_emit) begin
                    if (i_stat.out_free) begin
                        o_cmd.op = OP_EMIT;
                        n_emit   = 1'b0;
                    end
                end else if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                n_emit  = 1'b1;
                if (i_stat.mode) begin
                    o_cmd.op = OP_ABANDON;
                    n_emit   = 1'b0;
                end else if (i_stat.canc_pend && i_stat.held) begin
                    o_cmd.op = OP_CANCEL;
                end else if (i_stat.rel_pend) begin
                    o_cmd.op = OP_DEFER;
                end else if (i_stat.pressed && !i_stat.live) begin
                    o_cmd.op = OP_PRESS;
                end else if (!i_stat.live) begin
                    o_cmd.op = OP_ABSENT;
                end else begin
                    o_cmd.op = OP_CARRY;
                    n_emit   = 1'b0;
                    n_state  = i_stat.el_zero ? S_SQ_X : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.op = OP_MUL_RATE;
                n_state  = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.op = OP_MUL_INST;
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_cmd.op = OP_ADD;
                n_state  = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.op = OP_ROUND;
                n_state  = S_SQ_X;
            end
            S_SQ_X: begin
                o_cmd.op = OP_SQ_X;
                n_state  = S_SQ_Y;
            end
            S_SQ_Y: begin
                o_cmd.op = OP_SQ_Y;
                n_state  = S_SQ_L;
            end
            S_SQ_L: begin
                o_cmd.op = OP_SQ_L;
                n_state  = S_REACH;
            end
            S_REACH: begin
                o_cmd.op = OP_REACH;
                n_state  = S_IDLE;
                n_emit   = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
                n_emit  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

    // The divider leaves only after its last step.
    a_div_stay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_stat.div_last) |=> (r_state == S_DIV))
        else $error("divider left early");

    // A beat is written only when the output register can take it.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_EMIT) |-> i_stat.out_free)
        else $error("emit into a full output register");

    // No new sample is taken while a beat is still owed.
    a_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> !o_in_ready)
        else $error("sample taken with a beat owed");

endmodule
`default_nettype wire

/* rtl/tgt_dp.sv */
`default_nettype none
module tgt_dp import tgt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [IDX_W-1:0]     i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    tgt_in_if.sink                    i_in,
    tgt_out_if.source                 o_out
);

    // Configuration.
    logic [LIM_W-1:0]   r_lim;
    logic [SUM_W-1:0]   r_dlim;
    logic [RET_W-1:0]   r_ret;
    logic [FLOOR_W-1:0] r_floor;

    // Captured sample.
    logic                    r_mode, r_pressed, r_released, r_held;
    logic signed [POS_W-1:0] r_sx, r_sy, r_dx, r_dy;
    logic [EL_W-1:0]         r_el;

    // Contact state.
    logic                    r_live, r_relp, r_cancp, r_exc;
    logic signed [POS_W-1:0] r_start_x, r_start_y, r_last_x, r_last_y;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y, r_rate_y;
    logic [SUM_W-1:0]        r_dur;

    // Working registers.
    logic [EL_W-1:0]          r_rem;
    logic [NUM_W-1:0]         r_quo;
    logic [DCNT_W-1:0]        r_cnt;
    logic                     r_neg;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [PHASE_W-1:0]       r_phase;
    logic                     r_fling_en;
    logic                     r_ov;

    logic out_free;
    assign out_free = !r_ov || o_out.ready;

    assign o_stat.mode      = r_mode;
    assign o_stat.pressed   = r_pressed;
    assign o_stat.released  = r_released;
    assign o_stat.held      = r_held;
    assign o_stat.live      = r_live;
    assign o_stat.rel_pend  = r_relp;
    assign o_stat.canc_pend = r_cancp;
    assign o_stat.el_zero   = (r_el == '0);
    assign o_stat.div_last  = (r_cnt == DCNT_W'(DIV_STEPS - 1));
    assign o_stat.out_free  = out_free;

    // Saturating sums and held time.
    logic signed [SUM_W:0] sx_ext, sy_ext;
    logic signed [SUM_W-1:0] sum_x_sat, sum_y_sat;
    logic [SUM_W:0] dur_ext;
    logic [SUM_W-1:0] dur_sat;
    assign sx_ext = {r_sum_x[SUM_W-1], r_sum_x} + (SUM_W+1)'(r_dx);
    assign sy_ext = {r_sum_y[SUM_W-1], r_sum_y} + (SUM_W+1)'(r_dy);
    assign dur_ext = {1'b0, r_dur} + (SUM_W+1)'(r_el);
    always_comb begin
        sum_x_sat = sx_ext[SUM_W-1:0];
        if (sx_ext[SUM_W] != sx_ext[SUM_W-1]) begin
            sum_x_sat = sx_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        sum_y_sat = sy_ext[SUM_W-1:0];
        if (sy_ext[SUM_W] != sy_ext[SUM_W-1]) begin
            sum_y_sat = sy_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        dur_sat = dur_ext[SUM_W] ? {SUM_W{1'b1}} : dur_ext[SUM_W-1:0];
    end

    // Dividend for the instant rate: |step_y * 1000| plus half the tick length.
    logic signed [NUM_W:0] dy_scaled;
    logic [NUM_W-1:0]      dy_mag, div_num;
    assign dy_scaled = (NUM_W+1)'(r_dy) * (NUM_W+1)'(1000);
    assign dy_mag    = dy_scaled[NUM_W] ? NUM_W'(-dy_scaled) : dy_scaled[NUM_W-1:0];
    assign div_num   = dy_mag + NUM_W'(r_el >> 1);

    // One restoring divide step.
    logic [EL_W:0] div_trial;
    logic          div_bit;
    assign div_trial = {r_rem, r_quo[NUM_W-1]};
    assign div_bit   = (div_trial >= {1'b0, r_el});

    // Shared multiplier.
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic signed [NUM_W:0]     inst;
    assign inst = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_RATE: begin
                mul_a = MUL_W'(r_rate_y);
                mul_b = $signed(MUL_W'(r_ret));
            end
            OP_MUL_INST: begin
                mul_a = MUL_W'(inst);
                mul_b = $signed(MUL_W'(17'h10000 - {1'b0, r_ret}));
            end
            OP_SQ_X: begin
                mul_a = MUL_W'(r_sum_x);
                mul_b = MUL_W'(r_sum_x);
            end
            OP_SQ_Y: begin
                mul_a = MUL_W'(r_sum_y);
                mul_b = MUL_W'(r_sum_y);
            end
            OP_SQ_L: begin
                mul_a = $signed(MUL_W'(r_lim));
                mul_b = $signed(MUL_W'(r_lim));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Round the mix by 2^16, ties away from zero, then saturate.
    logic                    acc_neg;
    logic [ACC_W-1:0]        acc_mag, acc_rnd;
    logic [ACC_W-17:0]       acc_q;
    logic signed [SUM_W-1:0] rate_new;
    assign acc_neg = r_acc[ACC_W-1];
    assign acc_mag = acc_neg ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign acc_rnd = acc_mag + ACC_W'(32768);
    assign acc_q   = acc_rnd[ACC_W-1:16];
    always_comb begin
        if (!acc_neg && acc_q > (ACC_W-16)'(32'h7FFF_FFFF)) begin
            rate_new = {1'b0, {(SUM_W-1){1'b1}}};
        end else if (acc_neg && acc_q > (ACC_W-16)'(32'h8000_0000)) begin
            rate_new = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            rate_new = acc_neg ? -SUM_W'(acc_q) : SUM_W'(acc_q);
        end
    end

    // Release decisions at emit time.
    logic [SUM_W:0] rate_abs;
    logic           tap_ok, fling_ok;
    assign rate_abs = r_rate_y[SUM_W-1] ? -{r_rate_y[SUM_W-1], r_rate_y}
                                        : {1'b0, r_rate_y};
    assign tap_ok   = !r_exc && (r_dur <= r_dlim);
    assign fling_ok = r_fling_en && (rate_abs > (SUM_W+1)'(r_floor));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim   <= '0;
            r_dlim  <= '0;
            r_ret   <= '0;
            r_floor <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TRAVEL:   r_lim   <= i_cfg_data[LIM_W-1:0];
                REG_DURATION: r_dlim  <= i_cfg_data[SUM_W-1:0];
                REG_RETAIN:   r_ret   <= i_cfg_data[RET_W-1:0];
                REG_FLOOR:    r_floor <= i_cfg_data[FLOOR_W-1:0];
                default:      r_lim   <= r_lim;
            endcase
        end
    end

    // Sample capture and work registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_sx <= i_in.sample_x;
            r_sy <= i_in.sample_y;
            r_dx <= i_in.step_x;
            r_dy <= i_in.step_y;
            r_el <= i_in.elapsed_us;
        end
        case (i_cmd.op)
            OP_CARRY: begin
                r_rem <= '0;
                r_quo <= div_num;
                r_neg <= r_dy[POS_W-1];
            end
            OP_DIV_STEP: begin
                r_rem <= div_bit ? EL_W'(div_trial - {1'b0, r_el}) : div_trial[EL_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], div_bit};
            end
            OP_MUL_RATE: begin
                r_prod <= mul_p[PROD_W-1:0];
            end
            OP_MUL_INST, OP_SQ_Y: begin
                r_acc  <= ACC_W'(r_prod);
                r_prod <= mul_p[PROD_W-1:0];
            end
            OP_ADD: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            OP_SQ_X: begin
                r_prod <= mul_p[PROD_W-1:0];
            end
            OP_SQ_L: begin
                r_acc  <= r_acc + ACC_W'(r_prod);
                r_prod <= mul_p[PROD_W-1:0];
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    // Control flags and contact state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_pressed  <= 1'b0;
            r_released <= 1'b0;
            r_held     <= 1'b0;
            r_live     <= 1'b0;
            r_relp     <= 1'b0;
            r_cancp    <= 1'b0;
            r_exc      <= 1'b0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_last_x   <= '0;
            r_last_y   <= '0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_dur      <= '0;
            r_rate_y   <= '0;
            r_cnt      <= '0;
            r_phase    <= PH_ABSENT;
            r_fling_en <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            // The output register fills on an emit and empties when its beat is taken.
            if (i_cmd.op == OP_EMIT) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_mode     <= i_in.mode;
                    r_pressed  <= i_in.contact_pressed;
                    r_released <= i_in.contact_released;
                    r_held     <= i_in.contact_held;
                end
                OP_ABANDON: begin
                    if (r_live || r_relp) begin
                        r_cancp <= 1'b1;
                    end
                    r_live    <= 1'b0;
                    r_relp    <= 1'b0;
                    r_exc     <= 1'b0;
                    r_start_x <= '0;
                    r_start_y <= '0;
                    r_last_x  <= '0;
                    r_last_y  <= '0;
                    r_sum_x   <= '0;
                    r_sum_y   <= '0;
                    r_dur     <= '0;
                    r_rate_y  <= '0;
                end
                OP_CANCEL, OP_ABSENT: begin
                    r_cancp    <= 1'b0;
                    r_phase    <= PH_ABSENT;
                    r_fling_en <= 1'b0;
                end
                OP_DEFER: begin
                    r_cancp    <= 1'b0;
                    r_relp     <= 1'b0;
                    r_live     <= 1'b0;
                    r_phase    <= PH_RELEASED;
                    r_fling_en <= 1'b0;
                end
                OP_PRESS: begin
                    r_cancp    <= 1'b0;
                    r_exc      <= 1'b0;
                    r_start_x  <= r_sx;
                    r_start_y  <= r_sy;
                    r_last_x   <= r_sx;
                    r_last_y   <= r_sy;
                    r_sum_x    <= '0;
                    r_sum_y    <= '0;
                    r_dur      <= '0;
                    r_rate_y   <= '0;
                    r_live     <= 1'b1;
                    r_relp     <= r_released;
                    r_phase    <= PH_PRESSED;
                    r_fling_en <= 1'b0;
                end
                OP_CARRY: begin
                    r_cancp    <= 1'b0;
                    r_last_x   <= r_sx;
                    r_last_y   <= r_sy;
                    r_sum_x    <= sum_x_sat;
                    r_sum_y    <= sum_y_sat;
                    r_dur      <= dur_sat;
                    r_cnt      <= '0;
                    r_fling_en <= 1'b1;
                    if (r_released || !r_held) begin
                        r_live  <= 1'b0;
                        r_phase <= PH_RELEASED;
                    end else begin
                        r_phase <= PH_TRAVEL;
                    end
                end
                OP_DIV_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                OP_ROUND: begin
                    r_rate_y <= rate_new;
                end
                OP_REACH: begin
                    if ($unsigned(r_acc[PROD_W-1:0]) > $unsigned(r_prod)) begin
                        r_exc <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            o_out.phase           <= r_phase;
            o_out.tap_resolved    <= (r_phase == PH_RELEASED) && tap_ok;
            o_out.fling_resolved  <= (r_phase == PH_RELEASED) && fling_ok;
            o_out.travel_exceeded <= r_exc;
            o_out.origin_x        <= r_start_x;
            o_out.origin_y        <= r_start_y;
            o_out.position_x      <= r_last_x;
            o_out.position_y      <= r_last_y;
            o_out.total_x         <= r_sum_x;
            o_out.total_y         <= r_sum_y;
            o_out.held_time       <= r_dur;
            o_out.speed_y         <= r_rate_y;
        end
    end
    assign o_out.valid = r_ov;

    // A deferred release only exists for a live contact.
    a_relp_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_relp |-> r_live)
        else $error("release pending without a live contact");

    // A pending cancel never coexists with a live contact.
    a_cancp_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cancp |-> !r_live)
        else $error("cancel pending on a live contact");

    // A released phase always leaves the contact ended.
    a_rel_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT && r_phase == PH_RELEASED) |-> !r_live)
        else $error("release reported on a live contact");

endmodule
`default_nettype wire

/* rtl/touch_gesture_tap_fling_tracker.sv */
// A sample beat is loaded and decided, then its result is written to the output register.
// A live travel tick with a nonzero tick length runs 26 bit-serial divider steps, then five
// passes on the shared 33x33 multiplier plus add, round and compare steps; a zero tick
// length skips the divider, two rate passes, add and round. Abandon beats emit nothing.
// A new sample is taken once the result is written, later if the output register is full.
// Reset (synchronous, active low) clears the configuration and contact state to zero.
`default_nettype none
module touch_gesture_tap_fling_tracker import tgt_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    tgt_in_if.sink                i_in,
    tgt_out_if.source             o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready = w_in_ready;

    // Sequencer.
    tgt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // State, arithmetic and output register.
    tgt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire
